>>> rtl/core/tqbla_pkg.sv
// Shared types and constants for the two-queue burst-limited arbiter.
`default_nettype none

package tqbla_pkg;

   // Field widths
   localparam int TAG_W   = 16;
   localparam int LIMIT_W = 4;

   // Queue sizing and register defaults
   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int CMDQ_DEPTH      = 2;
   localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W      = $clog2(CMDQ_DEPTH + 1);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
   localparam logic [LIMIT_W-1:0] BURST_MAX   = 4'd15;

   // Command codes
   typedef enum logic [1:0] {
      CMD_ARRIVE_GEN = 2'd0,
      CMD_ARRIVE_PRI = 2'd1,
      CMD_SERVE      = 2'd2,
      CMD_FINISH     = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_SERVED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // Request payload
   typedef struct packed {
      logic [1:0]       command;
      logic [TAG_W-1:0] client_tag;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [1:0]       status;
      logic [TAG_W-1:0] served_tag;
      logic             from_priority;
      logic             last;
   } rsp_type;

   // Classified operation handed from front to back
   typedef struct packed {
      logic             arrive;
      logic             to_priority;
      logic             serve;
      logic             finish;
      logic [TAG_W-1:0] tag;
   } op_type;

endpackage

`default_nettype wire

>>> rtl/core/tqbla_front.sv
// Front end: takes requests, decodes the command and queues the operation.
`default_nettype none

module tqbla_front
   import tqbla_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  req_type      req_item,
   output logic         busy,
   output logic         op_valid,
   input  wire logic    op_pop,
   output op_type       op
);

   op_type                op_q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;
   op_type                decoded;
   logic                  push;
   logic                  pop;

   // Decode the command into operation flags; a priority arrival also sets to_priority
   always_comb begin
      decoded             = '0;
      decoded.tag         = req_item.client_tag;
      case (req_item.command)
         CMD_ARRIVE_GEN: begin
            decoded.arrive = 1'b1;
         end
         CMD_ARRIVE_PRI: begin
            decoded.arrive      = 1'b1;
            decoded.to_priority = 1'b1;
         end
         CMD_SERVE: begin
            decoded.serve = 1'b1;
         end
         default: begin
            decoded.finish = 1'b1;
         end
      endcase
   end

   // Command queue handshake
   assign busy     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push     = start && !busy;
   assign pop      = op_pop && (count_ff != '0);
   assign op_valid = (count_ff != '0);
   assign op       = op_q_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         op_q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tqbla_back.sv
// Back end: the two tag queues, burst arbitration, drain sequencing and result register.
`default_nettype none

module tqbla_back
   import tqbla_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_valid,
   input  op_type                  op,
   output logic                    op_pop,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_wdata,
   output logic                    rsp_valid,
   output rsp_type                 rsp_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      S_RUN   = 2'b01,
      S_DRAIN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [TAG_W-1:0]   gen_mem [QUEUE_DEPTH];
   logic [TAG_W-1:0]   pri_mem [QUEUE_DEPTH];
   logic [TAG_W-1:0]   gen_rd_ff;
   logic [TAG_W-1:0]   pri_rd_ff;
   logic [PTR_W-1:0]   gen_head_ff, gen_head_in, gen_tail_ff, gen_tail_in;
   logic [PTR_W-1:0]   pri_head_ff, pri_head_in, pri_tail_ff, pri_tail_in;
   logic [CNT_W-1:0]   gen_cnt_ff, gen_cnt_in, pri_cnt_ff, pri_cnt_in;
   logic [LIMIT_W-1:0] burst_ff, burst_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               res_valid_ff, res_valid_in;
   status_type         res_status_ff, res_status_in;
   logic               res_prio_ff, res_prio_in;
   logic               res_last_ff, res_last_in;
   logic               res_mem_ff, res_mem_in;
   logic               push_gen, push_pri, pop_gen, pop_pri;
   logic               gen_some, pri_some, gen_full, pri_full, pick_pri, drain_last;

   // Queue status
   assign gen_some   = (gen_cnt_ff != '0);
   assign pri_some   = (pri_cnt_ff != '0);
   assign gen_full   = (gen_cnt_ff == CNT_FULL);
   assign pri_full   = (pri_cnt_ff == CNT_FULL);
   assign pick_pri   = pri_some && ((burst_ff < limit_ff) || !gen_some);
   assign drain_last = ((pri_cnt_ff == CNT_W'(1)) && !gen_some) ||
                       (!pri_some && (gen_cnt_ff == CNT_W'(1)));

   assign op_pop    = (state_ff == S_RUN) && op_valid;
   assign csr_ready = 1'b1;

   // Sequencer: one operation a cycle, or one drained client a cycle
   always_comb begin
      state_in      = state_ff;
      burst_in      = burst_ff;
      push_gen      = 1'b0;
      push_pri      = 1'b0;
      pop_gen       = 1'b0;
      pop_pri       = 1'b0;
      res_valid_in  = 1'b0;
      res_status_in = ST_ACCEPTED;
      res_prio_in   = 1'b0;
      res_last_in   = 1'b1;
      res_mem_in    = 1'b0;
      case (state_ff)
         S_RUN: begin
            if (op_valid) begin
               res_valid_in = 1'b1;
               if (op.arrive) begin
                  if (op.to_priority) begin
                     if (pri_full) res_status_in = ST_FULL;
                     else          push_pri      = 1'b1;
                  end else begin
                     if (gen_full) res_status_in = ST_FULL;
                     else          push_gen      = 1'b1;
                  end
               end else if (op.serve) begin
                  if (pick_pri) begin
                     pop_pri       = 1'b1;
                     res_status_in = ST_SERVED;
                     res_prio_in   = 1'b1;
                     res_mem_in    = 1'b1;
                     if (burst_ff != BURST_MAX) burst_in = burst_ff + 1'b1;
                  end else if (gen_some) begin
                     pop_gen       = 1'b1;
                     res_status_in = ST_SERVED;
                     res_mem_in    = 1'b1;
                     burst_in      = '0;
                  end else begin
                     res_status_in = ST_EMPTY;
                  end
               end else begin
                  // finish: report empty at once, else stream the queues out
                  if (!pri_some && !gen_some) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     res_valid_in = 1'b0;
                     state_in     = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            res_valid_in  = 1'b1;
            res_status_in = ST_SERVED;
            res_mem_in    = 1'b1;
            res_last_in   = drain_last;
            if (pri_some) begin
               pop_pri     = 1'b1;
               res_prio_in = 1'b1;
            end else begin
               pop_gen = 1'b1;
            end
            if (drain_last) state_in = S_RUN;
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   // Pointer and count update
   always_comb begin
      gen_head_in = gen_head_ff;
      gen_tail_in = gen_tail_ff;
      gen_cnt_in  = gen_cnt_ff;
      pri_head_in = pri_head_ff;
      pri_tail_in = pri_tail_ff;
      pri_cnt_in  = pri_cnt_ff;
      if (push_gen) begin
         gen_tail_in = (gen_tail_ff == PTR_LAST) ? '0 : gen_tail_ff + 1'b1;
         gen_cnt_in  = gen_cnt_ff + 1'b1;
      end
      if (pop_gen) begin
         gen_head_in = (gen_head_ff == PTR_LAST) ? '0 : gen_head_ff + 1'b1;
         gen_cnt_in  = gen_cnt_ff - 1'b1;
      end
      if (push_pri) begin
         pri_tail_in = (pri_tail_ff == PTR_LAST) ? '0 : pri_tail_ff + 1'b1;
         pri_cnt_in  = pri_cnt_ff + 1'b1;
      end
      if (pop_pri) begin
         pri_head_in = (pri_head_ff == PTR_LAST) ? '0 : pri_head_ff + 1'b1;
         pri_cnt_in  = pri_cnt_ff - 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         gen_head_ff  <= '0;
         gen_tail_ff  <= '0;
         gen_cnt_ff   <= '0;
         pri_head_ff  <= '0;
         pri_tail_ff  <= '0;
         pri_cnt_ff   <= '0;
         burst_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_head_ff  <= gen_head_in;
         gen_tail_ff  <= gen_tail_in;
         gen_cnt_ff   <= gen_cnt_in;
         pri_head_ff  <= pri_head_in;
         pri_tail_ff  <= pri_tail_in;
         pri_cnt_ff   <= pri_cnt_in;
         burst_ff     <= burst_in;
         res_valid_ff <= res_valid_in;
         if (csr_valid) limit_ff <= csr_wdata;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_prio_ff   <= res_prio_in;
      res_last_ff   <= res_last_in;
      res_mem_ff    <= res_mem_in;
   end

   // General queue memory, registered read
   always_ff @(posedge clock) begin
      if (push_gen) gen_mem[gen_tail_ff] <= op.tag;
      if (pop_gen)  gen_rd_ff <= gen_mem[gen_head_ff];
   end

   // Priority queue memory, registered read
   always_ff @(posedge clock) begin
      if (push_pri) pri_mem[pri_tail_ff] <= op.tag;
      if (pop_pri)  pri_rd_ff <= pri_mem[pri_head_ff];
   end

   // Result ports
   assign rsp_valid              = res_valid_ff;
   assign rsp_item.status        = res_status_ff;
   assign rsp_item.served_tag    = !res_mem_ff ? '0 : (res_prio_ff ? pri_rd_ff : gen_rd_ff);
   assign rsp_item.from_priority = res_prio_ff;
   assign rsp_item.last          = res_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/two_queue_burst_limited_arbiter_unit.sv
// Top level of the two-queue burst-limited arbiter.
//
// Commands are taken when start is high and busy is low, and land in a
// two-entry command queue; busy rises only when that queue is full. The back
// end executes one command per cycle while no finish is draining, so arrivals
// and serves sustain one command per cycle, each result passing through the
// command queue and the result register to rsp_valid. A finish streams one
// result per cycle per queued client, priority queue first, or reports empty
// at once when both queues are empty. Results are shown for exactly one
// cycle and cannot be held off. The burst limit register is written through
// the csr port, which is always ready; the tag memories need no clearing pass.
`default_nettype none

module two_queue_burst_limited_arbiter_unit
   import tqbla_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  req_type                 req_item,
   output logic                    rsp_valid,
   output rsp_type                 rsp_item,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   op_type op;
   logic   op_valid;
   logic   op_pop;

   tqbla_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .op       (op)
   );

   tqbla_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_pop    (op_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

>>> rtl/core/tqbla_checker.sv
// Port-level checks for the arbiter, bound to the top level.
`default_nettype none

module tqbla_checker
   import tqbla_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input rsp_type                 rsp_item
);

   // No result directly after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Arrival and empty results carry no tag and close their request
   a_no_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ST_SERVED)) |->
      (rsp_item.served_tag == '0 && !rsp_item.from_priority && rsp_item.last))
      else $error("non-serve result with tag, priority or open request");

   // A drain streams without gaps until its last result
   a_drain_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |=> rsp_valid)
      else $error("gap inside a drain");

   // Only a drain leaves a request open, and it is never an arrival
   a_open_is_served: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |-> (rsp_item.status == ST_SERVED))
      else $error("open request on a result that is not a service");

endmodule

bind two_queue_burst_limited_arbiter_unit tqbla_checker u_checker (.*);

`default_nettype wire
